// ----- rtl/iol_pkg.sv -----
package iol_pkg;

  localparam int DEPTH = 16;
  // index into the chain and a counter that can hold DEPTH itself
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_INSERT_AT  = 3'd1,
    ACT_REMOVE_AT  = 3'd2,
    ACT_FIND       = 3'd3,
    ACT_REVERSE    = 3'd4,
    ACT_CLEAR      = 3'd5,
    ACT_DUMP       = 3'd6,
    ACT_NONE       = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_RANGE   = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_MISSING = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [31:0] key;
    logic        [31:0] payload;
  } entry_t;

  // what one cell loads at the next edge
  typedef enum logic [2:0] {
    CELL_HOLD      = 3'd0,
    CELL_TAKE_PREV = 3'd1,
    CELL_TAKE_NEXT = 3'd2,
    CELL_TAKE_NEW  = 3'd3,
    CELL_TAKE_HEAD = 3'd4
  } cell_op_t;

endpackage

// ----- rtl/iol_cell.sv -----
module iol_cell (
  input  logic              clk,
  input  iol_pkg::cell_op_t op_i,
  input  iol_pkg::entry_t   prev_i,
  input  iol_pkg::entry_t   next_i,
  input  iol_pkg::entry_t   new_i,
  input  iol_pkg::entry_t   head_i,
  output iol_pkg::entry_t   entry_o
);

  iol_pkg::entry_t entry_r;

  // hold one list entry; load from a neighbor, the request bus or the head
  always_ff @(posedge clk) begin
    case (op_i)
      iol_pkg::CELL_TAKE_PREV: entry_r <= prev_i;
      iol_pkg::CELL_TAKE_NEXT: entry_r <= next_i;
      iol_pkg::CELL_TAKE_NEW:  entry_r <= new_i;
      iol_pkg::CELL_TAKE_HEAD: entry_r <= head_i;
      default:                 entry_r <= entry_r;
    endcase
  end

  assign entry_o = entry_r;

endmodule

// ----- rtl/indexed_ordered_list_unit.sv -----
// Push, insert, remove, clear and unused codes answer in the cycle after the request
//   is taken with busy kept low, so they may follow every cycle.
// Find walks the whole list with busy high and answers after the walk; dump strobes
//   one entry a cycle while it walks the list; reverse answers after its walk.
// Empty lists (and a list of one for reverse) answer at once, without a walk.
// Reset (synchronous, rst_n low) empties the list, drops pending results; no stall.
module indexed_ordered_list_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_action,
  input  logic signed [31:0] in_item_key,
  input  logic [31:0]        in_item_payload,
  input  logic [7:0]         in_position,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_key,
  output logic [31:0]        out_payload,
  output logic               out_entry_valid,
  output logic [7:0]         out_list_count,
  output logic               out_last
);

  localparam int IDX_W = iol_pkg::IDX_W;
  localparam int CNT_W = iol_pkg::CNT_W;
  localparam int DEPTH = iol_pkg::DEPTH;

  // chain control: how the row of cells moves this cycle
  typedef enum logic [1:0] {
    MODE_HOLD,
    MODE_INSERT,   // cells above slot take prev, slot takes the request entry
    MODE_REMOVE,   // cells at and above slot take next
    MODE_ROTATE    // cells below slot take next, slot takes the head
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_t;

  state_t               state_r, state_nxt;
  iol_pkg::action_t     act_r, act_nxt;
  logic signed [31:0]   seek_key_r, seek_key_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     step_r, step_nxt;
  logic [CNT_W-1:0]     walk_end_r, walk_end_nxt;
  logic                 found_r, found_nxt;
  iol_pkg::entry_t      found_entry_r, found_entry_nxt;

  logic                 res_valid_r, res_valid_nxt;
  iol_pkg::status_t     res_status_r, res_status_nxt;
  iol_pkg::entry_t      res_entry_r, res_entry_nxt;
  logic                 res_has_r, res_has_nxt;
  logic [7:0]           res_count_r, res_count_nxt;
  logic                 res_last_r, res_last_nxt;

  mode_t                mode;
  logic [IDX_W-1:0]     slot;

  iol_pkg::entry_t      cells [DEPTH];
  iol_pkg::cell_op_t    cell_ops [DEPTH];
  iol_pkg::entry_t      new_entry;
  iol_pkg::entry_t      head;

  iol_pkg::action_t     req_act;
  logic [8:0]           pos_ext;
  logic [8:0]           count_ext;
  logic [7:0]           pos_m1;
  logic                 full;
  logic                 ins_ok;
  logic                 rem_ok;
  logic                 head_match;
  logic                 walk_done;
  logic [CNT_W-1:0]     rev_slot;
  logic [CNT_W-1:0]     tail_slot;

  assign req_act   = iol_pkg::action_t'(in_action);
  assign new_entry = '{key: in_item_key, payload: in_item_payload};
  assign head      = cells[0];

  assign pos_ext   = {1'b0, in_position};
  assign count_ext = 9'(count_r);
  assign pos_m1    = in_position - 8'd1;
  assign full      = (count_r == CNT_W'(DEPTH));
  assign ins_ok    = (pos_ext != 9'd0) && (pos_ext <= count_ext + 9'd1);
  assign rem_ok    = (pos_ext != 9'd0) && (pos_ext <= count_ext);

  assign head_match = (head.key == seek_key_r);
  assign walk_done  = (step_r == walk_end_r);
  assign tail_slot  = count_r - CNT_W'(1);
  assign rev_slot   = count_r - CNT_W'(1) - step_r;

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    state_nxt       = state_r;
    act_nxt         = act_r;
    seek_key_nxt    = seek_key_r;
    count_nxt       = count_r;
    step_nxt        = step_r;
    walk_end_nxt    = walk_end_r;
    found_nxt       = found_r;
    found_entry_nxt = found_entry_r;
    mode            = MODE_HOLD;
    slot            = '0;
    res_valid_nxt   = 1'b0;
    res_status_nxt  = iol_pkg::STAT_OK;
    res_entry_nxt   = '0;
    res_has_nxt     = 1'b0;
    res_last_nxt    = 1'b1;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          res_valid_nxt = 1'b1;
          case (req_act)
            iol_pkg::ACT_PUSH_FRONT: begin
              if (full) begin
                res_status_nxt = iol_pkg::STAT_FULL;
              end else begin
                mode      = MODE_INSERT;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            iol_pkg::ACT_INSERT_AT: begin
              // range is checked before fullness
              if (!ins_ok) begin
                res_status_nxt = iol_pkg::STAT_RANGE;
              end else if (full) begin
                res_status_nxt = iol_pkg::STAT_FULL;
              end else begin
                mode      = MODE_INSERT;
                slot      = pos_m1[IDX_W-1:0];
                count_nxt = count_r + CNT_W'(1);
              end
            end
            iol_pkg::ACT_REMOVE_AT: begin
              if (!rem_ok) begin
                res_status_nxt = iol_pkg::STAT_RANGE;
              end else begin
                mode      = MODE_REMOVE;
                slot      = pos_m1[IDX_W-1:0];
                count_nxt = count_r - CNT_W'(1);
              end
            end
            iol_pkg::ACT_CLEAR: begin
              count_nxt = '0;
            end
            iol_pkg::ACT_FIND, iol_pkg::ACT_DUMP: begin
              // empty list: answer at once (missing for find, lone marker for dump)
              if (count_r == '0) begin
                if (req_act == iol_pkg::ACT_FIND) begin
                  res_status_nxt = iol_pkg::STAT_MISSING;
                end
              end else begin
                res_valid_nxt = 1'b0;
                state_nxt     = ST_WALK;
                act_nxt       = req_act;
                seek_key_nxt  = in_item_key;
                step_nxt      = '0;
                walk_end_nxt  = count_r - CNT_W'(1);
                found_nxt     = 1'b0;
              end
            end
            iol_pkg::ACT_REVERSE: begin
              if (count_r > CNT_W'(1)) begin
                res_valid_nxt = 1'b0;
                state_nxt     = ST_WALK;
                act_nxt       = req_act;
                step_nxt      = '0;
                walk_end_nxt  = count_r - CNT_W'(2);
              end
            end
            default: begin
              // unused code: acknowledge, change nothing
            end
          endcase
        end
      end

      ST_WALK: begin
        mode     = MODE_ROTATE;
        step_nxt = step_r + CNT_W'(1);
        if (walk_done) begin
          state_nxt = ST_IDLE;
        end
        case (act_r)
          iol_pkg::ACT_DUMP: begin
            // emit the head, then rotate it to the tail
            slot          = tail_slot[IDX_W-1:0];
            res_valid_nxt = 1'b1;
            res_has_nxt   = 1'b1;
            res_entry_nxt = head;
            res_last_nxt  = walk_done;
          end
          iol_pkg::ACT_FIND: begin
            // one full turn leaves the order as it was; keep the first hit
            slot = tail_slot[IDX_W-1:0];
            if (!found_r && head_match) begin
              found_nxt       = 1'b1;
              found_entry_nxt = head;
            end
            if (walk_done) begin
              res_valid_nxt = 1'b1;
              if (found_r) begin
                res_has_nxt   = 1'b1;
                res_entry_nxt = found_entry_r;
              end else if (head_match) begin
                res_has_nxt   = 1'b1;
                res_entry_nxt = head;
              end else begin
                res_status_nxt = iol_pkg::STAT_MISSING;
              end
            end
          end
          default: begin
            // reverse: drop the head one place further down each step
            slot          = rev_slot[IDX_W-1:0];
            res_valid_nxt = walk_done;
          end
        endcase
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    res_count_nxt = 8'(count_nxt);
  end

  // per-cell load select; every cell compares its own place against the slot
  for (genvar i = 0; i < DEPTH; i++) begin : g_ctl
    localparam logic [IDX_W-1:0] CI = IDX_W'(i);
    always_comb begin
      case (mode)
        MODE_INSERT: begin
          if (CI == slot) cell_ops[i] = iol_pkg::CELL_TAKE_NEW;
          else if (CI > slot) cell_ops[i] = iol_pkg::CELL_TAKE_PREV;
          else cell_ops[i] = iol_pkg::CELL_HOLD;
        end
        MODE_REMOVE: begin
          if (CI >= slot) cell_ops[i] = iol_pkg::CELL_TAKE_NEXT;
          else cell_ops[i] = iol_pkg::CELL_HOLD;
        end
        MODE_ROTATE: begin
          if (CI == slot) cell_ops[i] = iol_pkg::CELL_TAKE_HEAD;
          else if (CI < slot) cell_ops[i] = iol_pkg::CELL_TAKE_NEXT;
          else cell_ops[i] = iol_pkg::CELL_HOLD;
        end
        default: cell_ops[i] = iol_pkg::CELL_HOLD;
      endcase
    end
  end

  // the row of cells; the first cell ties prev to a bus it never selects, the last ties next to the head
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    iol_pkg::entry_t prev_e;
    iol_pkg::entry_t next_e;
    if (i == 0) begin : g_first
      assign prev_e = new_entry;
    end else begin : g_mid_prev
      assign prev_e = cells[i-1];
    end
    if (i == DEPTH - 1) begin : g_lastc
      assign next_e = head;
    end else begin : g_mid_next
      assign next_e = cells[i+1];
    end
    iol_cell u_cell (
      .clk     (clk),
      .op_i    (cell_ops[i]),
      .prev_i  (prev_e),
      .next_i  (next_e),
      .new_i   (new_entry),
      .head_i  (head),
      .entry_o (cells[i])
    );
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  // walk context and result payload
  always_ff @(posedge clk) begin
    act_r         <= act_nxt;
    seek_key_r    <= seek_key_nxt;
    step_r        <= step_nxt;
    walk_end_r    <= walk_end_nxt;
    found_r       <= found_nxt;
    found_entry_r <= found_entry_nxt;
    res_status_r  <= res_status_nxt;
    res_entry_r   <= res_entry_nxt;
    res_has_r     <= res_has_nxt;
    res_count_r   <= res_count_nxt;
    res_last_r    <= res_last_nxt;
  end

  assign out_valid       = res_valid_r;
  assign out_status      = res_status_r;
  assign out_key         = res_entry_r.key;
  assign out_payload     = res_entry_r.payload;
  assign out_entry_valid = res_has_r;
  assign out_list_count  = res_count_r;
  assign out_last        = res_last_r;

  // the list never grows past its cells
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  // a walk only runs over a non-empty list
  a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (count_r != '0))
    else $error("walk over empty list");

  // the final result of a request leaves the block idle; earlier ones come mid-dump
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == !busy))
    else $error("last flag disagrees with busy");

  // a push into a list with room adds exactly one entry
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (req_act == iol_pkg::ACT_PUSH_FRONT) && !full)
      |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("push did not add one entry");

endmodule
